// ===== src/tpht_pkg.sv =====
`timescale 1ns / 1ps

package tpht_pkg;

   // Field widths of one pose and of its keys.
   localparam int WORD_W     = 32;
   localparam int NS_W       = 63;
   localparam int KEY_W      = 54;
   localparam int POSE_WORDS = 7;

   // Microsecond key: the nanosecond time divided by this constant.
   localparam int DIV_CONST  = 1000;
   localparam int DIGIT_W    = 4;
   localparam int REM_W      = 10;
   localparam int PART_W     = REM_W + DIGIT_W;
   localparam int DIVIDEND_W = 64;

   // Operation codes of a request word.
   localparam logic OP_STORE = 1'b0;
   localparam logic OP_TAKE  = 1'b1;

   typedef logic [POSE_WORDS-1:0][WORD_W-1:0] pose_type;

   typedef struct packed {
      logic              operation;
      logic [WORD_W-1:0] frame_index;
      logic [NS_W-1:0]   time_ns;
      logic [KEY_W-1:0]  query_us;
      pose_type          pose;
   } req_word_type;

   typedef struct packed {
      logic              found;
      logic [WORD_W-1:0] frame_index;
      logic [NS_W-1:0]   time_ns;
      pose_type          pose;
   } rsp_word_type;

   typedef struct packed {
      logic [NS_W-1:0]   time_ns;
      logic [WORD_W-1:0] frame_index;
      pose_type          pose;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_step;
      logic scan_read;
      logic scan_cmp;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_last;
      logic scan_end;
      logic match;
   } stat_type;

   // Multiples of the divisor, used by the radix-16 digit step.
   function automatic logic [PART_W-1:0] div_mult(logic [DIGIT_W-1:0] k);
      return PART_W'(int'(k) * DIV_CONST);
   endfunction

endpackage

// ===== src/tpht_req_if.sv =====
`timescale 1ns / 1ps

interface tpht_req_if;
   import tpht_pkg::*;

   logic              valid;
   logic              ready;
   logic              operation;
   logic [WORD_W-1:0] frame_index;
   logic [NS_W-1:0]   presentation_time_ns;
   logic [KEY_W-1:0]  query_time_us;
   logic [WORD_W-1:0] position_x;
   logic [WORD_W-1:0] position_y;
   logic [WORD_W-1:0] position_z;
   logic [WORD_W-1:0] orientation_0;
   logic [WORD_W-1:0] orientation_1;
   logic [WORD_W-1:0] orientation_2;
   logic [WORD_W-1:0] orientation_3;

   modport source (
      output valid, operation, frame_index, presentation_time_ns, query_time_us,
             position_x, position_y, position_z,
             orientation_0, orientation_1, orientation_2, orientation_3,
      input  ready
   );

   modport sink (
      input  valid, operation, frame_index, presentation_time_ns, query_time_us,
             position_x, position_y, position_z,
             orientation_0, orientation_1, orientation_2, orientation_3,
      output ready
   );

endinterface

// ===== src/tpht_rsp_if.sv =====
`timescale 1ns / 1ps

interface tpht_rsp_if;
   import tpht_pkg::*;

   logic              valid;
   logic              ready;
   logic              found;
   logic [WORD_W-1:0] out_frame_index;
   logic [NS_W-1:0]   out_time_ns;
   logic [WORD_W-1:0] out_position_x;
   logic [WORD_W-1:0] out_position_y;
   logic [WORD_W-1:0] out_position_z;
   logic [WORD_W-1:0] out_orientation_0;
   logic [WORD_W-1:0] out_orientation_1;
   logic [WORD_W-1:0] out_orientation_2;
   logic [WORD_W-1:0] out_orientation_3;

   modport source (
      output valid, found, out_frame_index, out_time_ns,
             out_position_x, out_position_y, out_position_z,
             out_orientation_0, out_orientation_1, out_orientation_2, out_orientation_3,
      input  ready
   );

   modport sink (
      input  valid, found, out_frame_index, out_time_ns,
             out_position_x, out_position_y, out_position_z,
             out_orientation_0, out_orientation_1, out_orientation_2, out_orientation_3,
      output ready
   );

endinterface

// ===== src/tpht_ctrl.sv =====
`timescale 1ns / 1ps

module tpht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_op,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  tpht_pkg::stat_type stat,
   output tpht_pkg::cmd_type  cmd
);
   import tpht_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DIV    = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_CMP    = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Sequence one word: key division for a store, ring scan, then state update.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (req_op == OP_TAKE) ? ST_SCAN : ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.scan_end) begin
               state_in = ST_FINISH;
            end else begin
               cmd.scan_read = 1'b1;
               state_in      = ST_CMP;
            end
         end
         ST_CMP: begin
            cmd.scan_cmp = 1'b1;
            state_in     = stat.match ? ST_FINISH : ST_SCAN;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The result register is full from commit until the receiver takes it.
   assign rsp_valid_in = cmd.commit | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/tpht_dp.sv =====
`timescale 1ns / 1ps

module tpht_dp #(
   parameter int HISTORY_DEPTH = 16,
   parameter int CNT_W         = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tpht_pkg::req_word_type req_word,
   input  tpht_pkg::cmd_type      cmd,
   output tpht_pkg::stat_type     stat,
   output tpht_pkg::rsp_word_type rsp_word,
   output logic [CNT_W-1:0]       hist_count
);
   import tpht_pkg::*;

   localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int SUM_W = CNT_W + 1;

   // Ring index of base plus off, where off never exceeds the depth.
   function automatic logic [IDX_W-1:0] ring_add(logic [IDX_W-1:0] base,
                                                 logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] s;
      s = SUM_W'(base) + SUM_W'(off);
      if (s >= SUM_W'(HISTORY_DEPTH)) begin
         s = s - SUM_W'(HISTORY_DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

   // History storage.
   logic [KEY_W-1:0] key_mem [HISTORY_DEPTH];
   entry_type        ent_mem [HISTORY_DEPTH];

   req_word_type     item_ff, item_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [3:0]       digit_cnt_ff, digit_cnt_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] lt_cnt_ff, lt_cnt_in;
   logic             lt_run_ff, lt_run_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] oldest_ff, oldest_in;
   logic [CNT_W-1:0] count_ff, count_in;
   rsp_word_type     rsp_ff, rsp_in;
   logic [KEY_W-1:0] rd_key_ff;
   entry_type        rd_ent_ff;

   logic [DIVIDEND_W-1:0] dividend;
   logic [DIGIT_W-1:0]    digit;
   logic [PART_W-1:0]     part;
   logic [DIGIT_W-1:0]    qdigit;
   logic [PART_W-1:0]     part_rem;
   logic [IDX_W-1:0]      slot_cur;
   logic [CNT_W-1:0]      pos_next;
   logic                  is_store;

   assign is_store = (item_ff.operation == OP_STORE);
   assign slot_cur = ring_add(oldest_ff, pos_ff);
   assign pos_next = pos_ff + CNT_W'(1);

   // One radix-16 digit of the division by 1000, most significant first.
   assign dividend = DIVIDEND_W'(item_ff.time_ns);
   assign digit    = dividend[{~digit_cnt_ff, 2'b00} +: DIGIT_W];
   assign part     = {rem_ff, digit};

   always_comb begin
      qdigit = '0;
      for (int k = 1; k < (1 << DIGIT_W); k++) begin
         if (part >= div_mult(DIGIT_W'(k))) begin
            qdigit = DIGIT_W'(k);
         end
      end
   end

   assign part_rem = part - div_mult(qdigit);

   // Status toward the controller.
   assign stat.div_last = (digit_cnt_ff == 4'hF);
   assign stat.scan_end = (pos_ff == count_ff);
   assign stat.match    = (rd_key_ff == key_ff);

   // Next-state logic of the working registers and the ring pointers.
   always_comb begin
      item_in      = item_ff;
      key_in       = key_ff;
      rem_in       = rem_ff;
      digit_cnt_in = digit_cnt_ff;
      pos_in       = pos_ff;
      lt_cnt_in    = lt_cnt_ff;
      lt_run_in    = lt_run_ff;
      hit_in       = hit_ff;
      oldest_in    = oldest_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;

      if (cmd.load) begin
         item_in      = req_word;
         key_in       = (req_word.operation == OP_TAKE) ? req_word.query_us : '0;
         rem_in       = '0;
         digit_cnt_in = '0;
         pos_in       = '0;
         lt_cnt_in    = '0;
         lt_run_in    = 1'b1;
         hit_in       = 1'b0;
      end

      if (cmd.div_step) begin
         key_in       = {key_ff[KEY_W-DIGIT_W-1:0], qdigit};
         rem_in       = part_rem[REM_W-1:0];
         digit_cnt_in = digit_cnt_ff + 4'd1;
      end

      // A miss moves on; leading keys below the query are counted while they last.
      if (cmd.scan_cmp) begin
         if (stat.match) begin
            hit_in = 1'b1;
         end else begin
            pos_in = pos_next;
            if (lt_run_ff && (rd_key_ff < key_ff)) begin
               lt_cnt_in = lt_cnt_ff + CNT_W'(1);
            end else begin
               lt_run_in = 1'b0;
            end
         end
      end

      if (cmd.commit) begin
         rsp_in       = '0;
         rsp_in.found = hit_ff;
         if (is_store) begin
            if (!hit_ff) begin
               if (count_ff < CNT_W'(HISTORY_DEPTH)) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  oldest_in = ring_add(oldest_ff, CNT_W'(1));
               end
            end
         end else if (hit_ff) begin
            rsp_in.frame_index = rd_ent_ff.frame_index;
            rsp_in.time_ns     = rd_ent_ff.time_ns;
            rsp_in.pose        = rd_ent_ff.pose;
            oldest_in          = ring_add(oldest_ff, pos_next);
            count_in           = count_ff - pos_next;
         end else begin
            oldest_in = ring_add(oldest_ff, lt_cnt_ff);
            count_in  = count_ff - lt_cnt_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         count_ff  <= '0;
      end else begin
         oldest_ff <= oldest_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      key_ff       <= key_in;
      rem_ff       <= rem_in;
      digit_cnt_ff <= digit_cnt_in;
      pos_ff       <= pos_in;
      lt_cnt_ff    <= lt_cnt_in;
      lt_run_ff    <= lt_run_in;
      hit_ff       <= hit_in;
      rsp_ff       <= rsp_in;
   end

   // Memory read: one ring slot per scan step, data registered.
   always_ff @(posedge clock) begin
      if (cmd.scan_read) begin
         rd_key_ff <= key_mem[slot_cur];
         rd_ent_ff <= ent_mem[slot_cur];
      end
   end

   // Memory write: a store lands on the matched slot or the slot after the newest.
   always_ff @(posedge clock) begin
      if (cmd.commit && is_store) begin
         key_mem[slot_cur] <= key_ff;
         ent_mem[slot_cur] <= '{time_ns:     item_ff.time_ns,
                                frame_index: item_ff.frame_index,
                                pose:        item_ff.pose};
      end
   end

   assign rsp_word   = rsp_ff;
   assign hist_count = count_ff;

endmodule

// ===== src/timestamped_pose_history_table_core.sv =====
`timescale 1ns / 1ps

// Pose history table. Words arrive on req_chan (valid/ready); each accepted word
// gives exactly one word on rsp_chan (valid/ready).
// A store word (operation 0) keys its pose by presentation_time_ns / 1000 and
// either overwrites the entry with that key in place (found = 1) or appends it,
// evicting the oldest entry when all HISTORY_DEPTH slots are in use.
// A take word (operation 1) returns the oldest entry whose key equals
// query_time_us and drops it with everything older; on a miss found = 0, the
// pose fields are zero, and leading entries with a smaller key are dropped.
// Steps: accept, radix-16 key division for a store only, then a scan over the
// history memory with one read and one compare per entry visited, a scan step
// that finds the end on a miss, and the commit. The result is valid in the
// cycle after the commit.
// One word is processed at a time.
// The result sits in an output register: the next word is accepted while it
// waits, but the commit of that next word holds until the receiver takes it.
// Synchronous reset empties the history at once; no clearing pass is needed.
module timestamped_pose_history_table_core #(
   parameter int HISTORY_DEPTH = 16
) (
   input logic       clock,
   input logic       reset,
   tpht_req_if.sink   req_chan,
   tpht_rsp_if.source rsp_chan
);
   import tpht_pkg::*;

   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

   req_word_type     req_word;
   rsp_word_type     rsp_word;
   cmd_type          cmd;
   stat_type         stat;
   logic [CNT_W-1:0] hist_count;

   // Gather the request fields into one word.
   assign req_word.operation   = req_chan.operation;
   assign req_word.frame_index = req_chan.frame_index;
   assign req_word.time_ns     = req_chan.presentation_time_ns;
   assign req_word.query_us    = req_chan.query_time_us;
   assign req_word.pose        = {req_chan.orientation_3, req_chan.orientation_2,
                                  req_chan.orientation_1, req_chan.orientation_0,
                                  req_chan.position_z, req_chan.position_y,
                                  req_chan.position_x};

   tpht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.operation),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tpht_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .CNT_W         (CNT_W)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_word   (rsp_word),
      .hist_count (hist_count)
   );

   // Spread the result word over the response fields.
   assign rsp_chan.found             = rsp_word.found;
   assign rsp_chan.out_frame_index   = rsp_word.frame_index;
   assign rsp_chan.out_time_ns       = rsp_word.time_ns;
   assign rsp_chan.out_position_x    = rsp_word.pose[0];
   assign rsp_chan.out_position_y    = rsp_word.pose[1];
   assign rsp_chan.out_position_z    = rsp_word.pose[2];
   assign rsp_chan.out_orientation_0 = rsp_word.pose[3];
   assign rsp_chan.out_orientation_1 = rsp_word.pose[4];
   assign rsp_chan.out_orientation_2 = rsp_word.pose[5];
   assign rsp_chan.out_orientation_3 = rsp_word.pose[6];

   // The history never holds more entries than it has slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      hist_count <= CNT_W'(HISTORY_DEPTH))
      else $error("history count exceeds depth");

   // Once a word is taken, no other is accepted in the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while busy");

   // While the block sits idle the history does not change.
   a_idle_stable: assert property (@(posedge clock) disable iff (reset)
      (req_chan.ready && $past(req_chan.ready)) |-> $stable(hist_count))
      else $error("history changed while idle");

   // A commit fills the result register only when it is free or being emptied.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result overwritten before it was taken");

endmodule
